FILE: src/utfwc_pkg.sv
// ----------------------------------------------------------------------------
// utfwc_pkg: shared types and constants of the text word/line counter
// Byte codes of the decoder, the count width and the saturating increment.
// ----------------------------------------------------------------------------
package utfwc_pkg;

  // Width of the internal counters. Result fields carry the low OUT_WIDTH bits.
  localparam int COUNT_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;
  localparam int NUM_FIELDS  = 5;
  localparam int TDATA_WIDTH = NUM_FIELDS * OUT_WIDTH;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [OUT_WIDTH-1:0]   field_t;

  localparam count_t COUNT_MAX = '1;

  // Kind of an input beat, carried on tuser.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  // Byte codes.
  localparam logic [7:0] BYTE_TAB     = 8'h09;
  localparam logic [7:0] BYTE_NL      = 8'h0A;
  localparam logic [7:0] BYTE_SPACE   = 8'h20;
  localparam logic [7:0] CONT_LO      = 8'h21;
  localparam logic [7:0] CONT_HI      = 8'h7E;
  localparam logic [7:0] LEAD_LATIN   = 8'hA0;
  localparam logic [7:0] LEAD_ONE_LO  = 8'hA1;
  localparam logic [7:0] LEAD_ONE_HI  = 8'hF5;
  localparam logic [7:0] LEAD_TWO_LO  = 8'hF6;
  localparam logic [7:0] LEAD_TWO_HI  = 8'hF7;
  localparam logic [7:0] LEAD_BAD_LO  = 8'hF8;

  // Increment that sticks at the counter maximum.
  function automatic count_t sat_bump(input count_t c, input logic en);
    sat_bump = (en && (c != COUNT_MAX)) ? c + count_t'(1) : c;
  endfunction

endpackage

FILE: src/utf_text_word_line_counter.sv
// ----------------------------------------------------------------------------
// utf_text_word_line_counter: line, word, rune, bad-code and byte counter
// Decodes a byte stream in the old multi-byte text encoding and reports the
// five totals when an end-of-file beat arrives.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                               Beats
//   in_      slave      tuser: operation, tdata: data_byte     one per text byte or EOF
//   out_     master     tdata: five 32-bit totals              one per EOF beat
//
// The block takes one input beat per clock cycle while in_tready is high. Each
// beat is first held in an input register; the decoder and the five counters
// update from it when it leaves that register. An end-of-file beat then loads
// the result register, and its totals appear on out_tdata with out_tvalid.
// Only an end-of-file beat waits on the output side: if the result register
// still holds an untaken result, the beat stays in the input register and
// in_tready falls until out_tready takes the old result. A data beat never
// waits in the input register.
// Reset (rst_n low, sampled at the clock) empties both registers, puts the
// decoder in its blank-space state and clears all counters.
//
module utf_text_word_line_counter
  import utfwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] operation: 0 data byte, 1 end of file
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [TDATA_WIDTH-1:0] out_tdata   // [31:0] line_count, [63:32] word_count,
                                             // [95:64] rune_count, [127:96] bad_count,
                                             // [159:128] byte_count
);

  // Decoder states: blank space, after a latin lead, two or one more bytes
  // needed, and inside a word.
  typedef enum logic [2:0] {
    ST_SPACE = 3'd0,
    ST_LATIN = 3'd1,
    ST_NEED2 = 3'd2,
    ST_NEED1 = 3'd3,
    ST_WORD  = 3'd4
  } dec_state_t;

  // Input register.
  logic                   s1_valid_r;
  logic                   s1_op_r;
  logic [7:0]             s1_byte_r;

  // Decoder and counters.
  dec_state_t             state_r, state_nxt;
  count_t                 lines_r, words_r, runes_r, bad_r, bytes_r;

  // Result register.
  logic                   out_valid_r;
  logic [TDATA_WIDTH-1:0] out_data_r;
  logic [TDATA_WIDTH-1:0] out_data_nxt;

  logic out_free;
  logic s1_go;
  logic in_take;

  logic blank, newline, cont, unfinished;
  logic inc_line, inc_word, inc_bad;
  count_t bad_eof;

  // The result register is free when empty or being drained this cycle.
  assign out_free   = !out_valid_r || out_tready;
  assign s1_go      = s1_valid_r && ((s1_op_r == OP_DATA) || out_free);
  assign in_tready  = !s1_valid_r || s1_go;
  assign in_take    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Byte classes and the transition of the decoder for one data byte.
  always_comb begin
    blank      = (s1_byte_r == BYTE_TAB) || (s1_byte_r == BYTE_SPACE);
    newline    = (s1_byte_r == BYTE_NL);
    unfinished = (state_r == ST_LATIN) || (state_r == ST_NEED2) ||
                 (state_r == ST_NEED1);
    cont       = 1'b0;
    inc_line   = 1'b0;
    inc_word   = 1'b0;
    inc_bad    = 1'b0;
    state_nxt  = state_r;

    if (unfinished) begin
      if (state_r == ST_LATIN) begin
        cont = (s1_byte_r >= LEAD_LATIN);
      end else begin
        cont = (s1_byte_r inside {[CONT_LO:CONT_HI]}) || (s1_byte_r >= LEAD_LATIN);
      end
      if (cont) begin
        state_nxt = (state_r == ST_NEED2) ? ST_NEED1 : ST_WORD;
      end else begin
        // A broken code: the byte that broke it still counts as a rune.
        inc_bad = 1'b1;
        if (newline) begin
          inc_line  = 1'b1;
          state_nxt = ST_SPACE;
        end else if (blank) begin
          state_nxt = ST_SPACE;
        end else begin
          state_nxt = ST_WORD;
        end
      end
    end else begin
      // Blank space or inside a word; any byte but tab, space and newline is part of a word.
      if (newline) begin
        inc_line  = 1'b1;
        state_nxt = ST_SPACE;
      end else if (blank) begin
        state_nxt = ST_SPACE;
      end else begin
        inc_word = (state_r != ST_WORD);
        if (s1_byte_r == LEAD_LATIN) begin
          state_nxt = ST_LATIN;
        end else if (s1_byte_r inside {[LEAD_ONE_LO:LEAD_ONE_HI]}) begin
          state_nxt = ST_NEED1;
        end else if (s1_byte_r inside {[LEAD_TWO_LO:LEAD_TWO_HI]}) begin
          state_nxt = ST_NEED2;
        end else if (s1_byte_r >= LEAD_BAD_LO) begin
          inc_bad   = 1'b1;
          state_nxt = ST_WORD;
        end else begin
          state_nxt = ST_WORD;
        end
      end
    end
  end

  // At end of file an unfinished code adds one bad code before the totals go out.
  assign bad_eof = sat_bump(bad_r, unfinished);

  assign out_data_nxt = {field_t'(bytes_r), field_t'(bad_eof), field_t'(runes_r),
                         field_t'(words_r), field_t'(lines_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ST_SPACE;
      lines_r     <= '0;
      words_r     <= '0;
      runes_r     <= '0;
      bad_r       <= '0;
      bytes_r     <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (in_take) begin
        s1_op_r   <= in_tuser;
        s1_byte_r <= in_tdata;
      end

      // The result stays until taken; an end-of-file beat loads a new one.
      out_valid_r <= (out_valid_r && !out_tready) || (s1_go && (s1_op_r == OP_EOF));

      if (s1_go) begin
        if (s1_op_r == OP_EOF) begin
          out_data_r  <= out_data_nxt;
          state_r     <= ST_SPACE;
          lines_r     <= '0;
          words_r     <= '0;
          runes_r     <= '0;
          bad_r       <= '0;
          bytes_r     <= '0;
        end else begin
          state_r <= state_nxt;
          lines_r <= sat_bump(lines_r, inc_line);
          words_r <= sat_bump(words_r, inc_word);
          runes_r <= sat_bump(runes_r, !cont);
          bad_r   <= sat_bump(bad_r, inc_bad);
          bytes_r <= sat_bump(bytes_r, 1'b1);
        end
      end
    end
  end

  // An end-of-file beat that leaves the input register always produces a result.
  a_eof_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && (s1_op_r == OP_EOF)) |=> out_valid_r)
    else $error("end-of-file beat did not load the result register");

  // Totals start over after an end-of-file beat.
  a_eof_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && (s1_op_r == OP_EOF)) |=> (bytes_r == '0 && state_r == ST_SPACE))
    else $error("counters not cleared after end of file");

  // Every rune is a byte, so the rune count never passes the byte count.
  a_runes_le_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    runes_r <= bytes_r)
    else $error("rune count exceeds byte count");

  // A held end-of-file beat with a stalled result blocks the input side.
  a_eof_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_op_r == OP_EOF) && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while end-of-file beat is blocked");

endmodule
